@@ hw/rtl/bvalu_pkg.sv @@
package bvalu_pkg;

	typedef enum logic [3:0] {
		CMD_AND    = 4'd0,
		CMD_NOT    = 4'd1,
		CMD_ADD    = 4'd2,
		CMD_SUB    = 4'd3,
		CMD_MUL    = 4'd4,
		CMD_ULT    = 4'd5,
		CMD_ULTE   = 4'd6,
		CMD_EQ     = 4'd7,
		CMD_SLL    = 4'd8,
		CMD_SRL    = 4'd9,
		CMD_UDIV   = 4'd10,
		CMD_UREM   = 4'd11,
		CMD_CONCAT = 4'd12,
		CMD_SLICE  = 4'd13,
		CMD_SELECT = 4'd14
	} cmd_t;

	localparam int unsigned OP_W     = 32;
	localparam int unsigned RES_W    = 64;
	localparam int unsigned RW_W     = 7;
	localparam int unsigned IDX_W    = 5;

endpackage

@@ hw/rtl/bvalu_div.sv @@
module bvalu_div import bvalu_pkg::*; #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned STAGES = 4
) (
	input  logic             clk,
	input  logic             adv,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic [WIDTH-1:0] quotient,
	output logic [WIDTH-1:0] remainder
);

	localparam int unsigned BPS = (WIDTH + STAGES - 1) / STAGES;
	localparam int unsigned TOT = BPS * STAGES;

	logic [TOT-1:0]   num_r [STAGES+1];
	logic [WIDTH-1:0] den_r [STAGES+1];
	logic [WIDTH-1:0] rem_r [STAGES+1];

	assign num_r[0] = TOT'(dividend);
	assign den_r[0] = divisor;
	assign rem_r[0] = '0;

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic [TOT-1:0]   num_n;
		logic [WIDTH-1:0] rem_n;

		always_comb begin
			logic [WIDTH:0] t;
			num_n = num_r[g];
			rem_n = rem_r[g];
			for (int k = 0; k < BPS; k++) begin
				t = {rem_n, num_n[TOT-1]};
				num_n = num_n << 1;
				if (t >= {1'b0, den_r[g]}) begin
					rem_n = WIDTH'(t - {1'b0, den_r[g]});
					num_n[0] = 1'b1;
				end else begin
					rem_n = t[WIDTH-1:0];
				end
			end
		end

		logic [TOT-1:0]   num_s;
		logic [WIDTH-1:0] den_s;
		logic [WIDTH-1:0] rem_s;
		always_ff @(posedge clk) begin
			if (adv) begin
				num_s <= num_n;
				den_s <= den_r[g];
				rem_s <= rem_n;
			end
		end
		assign num_r[g+1] = num_s;
		assign den_r[g+1] = den_s;
		assign rem_r[g+1] = rem_s;
	end

	assign quotient  = num_r[STAGES][WIDTH-1:0];
	assign remainder = rem_r[STAGES];

endmodule

@@ hw/rtl/bitvector_alu_core.sv @@
// Pipelined unsigned bit-vector ALU. One item is accepted per cycle while in_stall is low;
// every result is held in step with the four-stage restoring divider (WIDTH/4 quotient
// bits per stage, rounded up) and then passes the output register, for all operations.
// A stalled valid output freezes the whole pipeline; stall on the input is raised only then.
module bitvector_alu_core import bvalu_pkg::*; #(
	parameter int unsigned WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [3:0]           command,
	input  logic [OP_W-1:0]      operand_a,
	input  logic [OP_W-1:0]      operand_b,
	input  logic                 condition,
	input  logic [IDX_W-1:0]     slice_upper,
	input  logic [IDX_W-1:0]     slice_lower,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [RES_W-1:0]     result,
	output logic [RW_W-1:0]      result_width
);

	localparam int unsigned NST = 4;
	localparam int unsigned SH_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

	logic adv;
	logic [NST:0] vld_q;

	assign adv = !(vld_q[NST] && out_stall);
	assign in_stall = !adv;
	assign out_valid = vld_q[NST];

	logic [WIDTH-1:0] a, b;
	assign a = operand_a[WIDTH-1:0];
	assign b = operand_b[WIDTH-1:0];

	// stage 1: everything except divide
	logic [RES_W-1:0] res_c;
	logic [RW_W-1:0]  rw_c;
	logic [WIDTH-1:0] prod_c;
	logic [SH_W-1:0]  sh;
	logic [IDX_W-1:0] up, lo;

	always_comb begin
		sh = b[SH_W-1:0];
		up = (32'(slice_upper) > WIDTH - 1) ? IDX_W'(WIDTH - 1) : slice_upper;
		lo = (slice_lower > up) ? up : slice_lower;
		prod_c = WIDTH'(a * b);
		res_c = '0;
		rw_c = RW_W'(WIDTH);
		case (command)
			CMD_AND:    res_c = RES_W'(a & b);
			CMD_NOT:    res_c = RES_W'(WIDTH'(~a));
			CMD_ADD:    res_c = RES_W'(WIDTH'(a + b));
			CMD_SUB:    res_c = RES_W'(WIDTH'(a - b));
			CMD_MUL:    res_c = RES_W'(prod_c);
			CMD_ULT:    begin res_c = RES_W'(a < b);  rw_c = RW_W'(1); end
			CMD_ULTE:   begin res_c = RES_W'(a <= b); rw_c = RW_W'(1); end
			CMD_EQ:     begin res_c = RES_W'(a == b); rw_c = RW_W'(1); end
			CMD_SLL:    res_c = (32'(sh) >= WIDTH) ? '0 : RES_W'(WIDTH'(a << sh));
			CMD_SRL:    res_c = (32'(sh) >= WIDTH) ? '0 : RES_W'(a >> sh);
			CMD_UDIV, CMD_UREM: res_c = '0;
			CMD_CONCAT: begin
				res_c = RES_W'({a, b});
				rw_c = RW_W'(2 * WIDTH);
			end
			CMD_SLICE: begin
				rw_c = RW_W'(up - lo) + RW_W'(1);
				res_c = RES_W'(a >> lo) & ~({RES_W{1'b1}} << rw_c);
			end
			CMD_SELECT: res_c = RES_W'(condition ? a : b);
			default:    begin res_c = '0; rw_c = RW_W'(1); end
		endcase
	end

	logic [RES_W-1:0] res_s [NST];
	logic [RW_W-1:0]  rw_s  [NST];
	logic [3:0]       cmd_s [NST];
	logic [WIDTH-1:0] a_s   [NST];
	logic             bz_s  [NST];

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s[0] <= res_c;
			rw_s[0]  <= rw_c;
			cmd_s[0] <= command;
			a_s[0]   <= a;
			bz_s[0]  <= (b == '0);
			for (int i = 1; i < NST; i++) begin
				res_s[i] <= res_s[i-1];
				rw_s[i]  <= rw_s[i-1];
				cmd_s[i] <= cmd_s[i-1];
				a_s[i]   <= a_s[i-1];
				bz_s[i]  <= bz_s[i-1];
			end
		end
	end

	logic [WIDTH-1:0] quo, rem;

	bvalu_div #(.WIDTH(WIDTH), .STAGES(NST)) u_div (
		.clk(clk), .adv(adv),
		.dividend(a), .divisor(b),
		.quotient(quo), .remainder(rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-1:0], in_valid};
		end
	end

	// final mux: stage index NST-1 aligns with the divider output
	always_ff @(posedge clk) begin
		if (adv) begin
			result_width <= rw_s[NST-1];
			case (cmd_s[NST-1])
				CMD_UDIV: result <= bz_s[NST-1] ? RES_W'({WIDTH{1'b1}}) : RES_W'(quo);
				CMD_UREM: result <= bz_s[NST-1] ? RES_W'(a_s[NST-1]) : RES_W'(rem);
				default:  result <= res_s[NST-1];
			endcase
		end
	end

	// valid bits are all that reset touches; the first stage register tracks in_valid
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_q[0])
		else $error("accepted item lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(result))
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (result_width != '0))
		else $error("zero result width");

endmodule

@@ verif/tb_top.sv @@
module tb_top;
	import bvalu_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [3:0] CMD_UNUSED = 4'd15;
	localparam int unsigned N_RANDOM = 1880;
	localparam int unsigned CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [3:0]       cmd;
		logic [OP_W-1:0]  a;
		logic [OP_W-1:0]  b;
		logic             cond;
		logic [IDX_W-1:0] up;
		logic [IDX_W-1:0] lo;
		logic             known;
		logic [RES_W-1:0] res;
		logic [RW_W-1:0]  rw;
	} alu_row_t;

	typedef struct packed {
		logic [RES_W-1:0] res;
		logic [RW_W-1:0]  rw;
	} alu_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [3:0]           command = '0;
	logic [OP_W-1:0]      operand_a = '0;
	logic [OP_W-1:0]      operand_b = '0;
	logic                 condition = 1'b0;
	logic [IDX_W-1:0]     slice_upper = '0;
	logic [IDX_W-1:0]     slice_lower = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [RES_W-1:0]     result;
	logic [RW_W-1:0]      result_width;

	alu_result_t pending_results[$];
	int unsigned errors = 0;
	int unsigned cycles = 0;
	bit quiet = 1'b0;

	bitvector_alu_core #(.WIDTH(32)) u_top (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic alu_result_t alu_compute(input alu_row_t it);
		alu_result_t r;
		logic [OP_W-1:0] prod;
		logic [IDX_W-1:0] lo;
		r.res = '0;
		r.rw = 7'd32;
		case (it.cmd)
			CMD_AND: r.res = RES_W'(it.a & it.b);
			CMD_NOT: r.res = RES_W'(OP_W'(~it.a));
			CMD_ADD: r.res = RES_W'(OP_W'(it.a + it.b));
			CMD_SUB: r.res = RES_W'(OP_W'(it.a - it.b));
			CMD_MUL: begin
				prod = OP_W'(it.a * it.b);
				r.res = RES_W'(prod);
			end
			CMD_ULT: begin r.res = RES_W'(it.a < it.b); r.rw = 7'd1; end
			CMD_ULTE: begin r.res = RES_W'(it.a <= it.b); r.rw = 7'd1; end
			CMD_EQ: begin r.res = RES_W'(it.a == it.b); r.rw = 7'd1; end
			CMD_SLL: r.res = RES_W'(OP_W'(it.a << it.b[4:0]));
			CMD_SRL: r.res = RES_W'(it.a >> it.b[4:0]);
			CMD_UDIV: r.res = RES_W'((it.b == 0) ? {OP_W{1'b1}} : it.a / it.b);
			CMD_UREM: r.res = RES_W'((it.b == 0) ? it.a : it.a % it.b);
			CMD_CONCAT: begin r.res = {it.a, it.b}; r.rw = 7'd64; end
			CMD_SLICE: begin
				lo = (it.lo > it.up) ? it.up : it.lo;
				r.rw = 7'(it.up - lo + 1);
				r.res = RES_W'(it.a >> lo) & ((64'd1 << r.rw) - 64'd1);
			end
			CMD_SELECT: r.res = RES_W'(it.cond ? it.a : it.b);
			default: begin r.res = '0; r.rw = 7'd1; end
		endcase
		return r;
	endfunction

	function automatic logic [OP_W-1:0] pick_operand();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return $urandom_range(0, 15);
			3: return 32'h8000_0000 >> $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	task automatic send(input alu_row_t it);
		alu_result_t exp_r;
		if (!quiet && $urandom_range(0, 99) < 7) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		exp_r = alu_compute(it);
		if (it.known)
			exp_r = '{res: it.res, rw: it.rw};
		in_valid <= 1'b1;
		command <= it.cmd;
		operand_a <= it.a;
		operand_b <= it.b;
		condition <= it.cond;
		slice_upper <= it.up;
		slice_lower <= it.lo;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(exp_r);
	endtask

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected item: result=%h result_width=%0d", result, result_width);
				errors++;
			end else begin
				alu_result_t e;
				e = pending_results.pop_front();
				if (result !== e.res) begin
					$error("result: expected %h, got %h", e.res, result);
					errors++;
				end
				if (result_width !== e.rw) begin
					$error("result_width: expected %0d, got %0d", e.rw, result_width);
					errors++;
				end
			end
		end
		out_stall <= !quiet && ($urandom_range(0, 99) < 7);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	alu_row_t directed[] = '{
		'{CMD_AND, '1, '1, 0, 0, 0, 1, 64'hFFFF_FFFF, 7'd32},
		'{CMD_AND, 32'hA5A5_A5A5, 32'h0F0F_0F0F, 0, 0, 0, 0, 0, 0},
		'{CMD_NOT, '0, '0, 0, 0, 0, 1, 64'hFFFF_FFFF, 7'd32},
		'{CMD_ADD, '1, 32'd1, 0, 0, 0, 1, 64'h0, 7'd32},
		'{CMD_SUB, '0, 32'd1, 0, 0, 0, 1, 64'hFFFF_FFFF, 7'd32},
		'{CMD_MUL, '1, '1, 0, 0, 0, 1, 64'h1, 7'd32},
		'{CMD_ULT, '0, 32'd1, 0, 0, 0, 1, 64'h1, 7'd1},
		'{CMD_ULT, '1, '1, 0, 0, 0, 1, 64'h0, 7'd1},
		'{CMD_ULTE, '1, '1, 0, 0, 0, 1, 64'h1, 7'd1},
		'{CMD_EQ, 32'h1234_5678, 32'h1234_5678, 0, 0, 0, 1, 64'h1, 7'd1},
		'{CMD_SLL, '1, 32'hFFFF_FFFF, 0, 0, 0, 1, 64'h8000_0000, 7'd32},
		'{CMD_SRL, '1, 32'd31, 0, 0, 0, 1, 64'h1, 7'd32},
		'{CMD_UDIV, 32'd77, '0, 0, 0, 0, 1, 64'hFFFF_FFFF, 7'd32},
		'{CMD_UREM, 32'd77, '0, 0, 0, 0, 1, 64'd77, 7'd32},
		'{CMD_UDIV, '1, 32'd7, 0, 0, 0, 0, 0, 0},
		'{CMD_UREM, '1, 32'd7, 0, 0, 0, 0, 0, 0},
		'{CMD_CONCAT, '1, '0, 0, 0, 0, 1, 64'hFFFF_FFFF_0000_0000, 7'd64},
		'{CMD_SLICE, 32'hDEAD_BEEF, '0, 0, 5'd31, 5'd0, 1, 64'hDEAD_BEEF, 7'd32},
		'{CMD_SLICE, 32'h8000_0000, '0, 0, 5'd3, 5'd31, 1, 64'h0, 7'd1},
		'{CMD_SLICE, 32'hDEAD_BEEF, '0, 0, 5'd11, 5'd4, 0, 0, 0},
		'{CMD_SELECT, '1, '0, 1, 0, 0, 1, 64'hFFFF_FFFF, 7'd32},
		'{CMD_SELECT, '1, '0, 0, 0, 0, 1, 64'h0, 7'd32},
		'{CMD_UNUSED, '1, '1, 1, '1, '1, 1, 64'h0, 7'd1}
	};

	initial begin
		alu_row_t it;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send(directed[i]);
		for (int n = 0; n < N_RANDOM; n++) begin
			quiet = (n >= 700 && n < 1000);
			it = '0;
			it.cmd = ($urandom_range(0, 99) < 2) ? CMD_UNUSED : 4'($urandom_range(0, 14));
			it.a = pick_operand();
			it.b = pick_operand();
			if (it.cmd == CMD_EQ && $urandom_range(0, 1))
				it.b = it.a;
			it.cond = 1'($urandom_range(0, 1));
			it.up = IDX_W'($urandom);
			it.lo = IDX_W'($urandom);
			send(it);
		end
		quiet = 1'b0;
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

@@ files.f @@
hw/rtl/bvalu_pkg.sv
hw/rtl/bvalu_div.sv
hw/rtl/bitvector_alu_core.sv
verif/tb_top.sv
